>>> src/nbbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nbbt_pkg;

  // default geometry
  localparam int unsigned BLOCK_COUNT_DEF     = 1024;
  localparam int unsigned PAGE_BYTES_DEF      = 2048;
  localparam int unsigned PAGES_PER_BLOCK_DEF = 64;

  // widest table index the block count range calls for
  localparam int unsigned IDX_MAX_W = 16;

  // factory marker of a good block
  localparam logic [7:0] MARKER_GOOD = 8'hFF;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_SCAN   = 2'd1,
    OP_FAIL   = 2'd2,
    OP_ECC    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RS_GOOD      = 3'd0,
    RS_BAD       = 3'd1,
    RS_SCAN      = 3'd2,
    RS_RANGE     = 3'd3,
    RS_EMPTY     = 3'd4,
    RS_ECC_CLEAN = 3'd5,
    RS_ECC_FIXED = 3'd6,
    RS_ECC_FATAL = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    BS_UNKNOWN = 2'd0,
    BS_GOOD    = 2'd1,
    BS_BAD     = 2'd2
  } blk_state_t;

  typedef enum logic {
    MF_CLEAR,
    MF_RUN
  } mem_fsm_t;

  // decoded request, handed from the decoder to the update stage
  typedef struct packed {
    logic                 fixed;      // result does not depend on the table
    status_t              status;     // result code when fixed
    op_t                  kind;
    logic                 wr;         // report that writes the table back
    logic                 marker_bad;
    logic                 failed;
    logic [IDX_MAX_W-1:0] idx;
    logic [9:0]           blk;
    logic [15:0]          page;
    logic [10:0]          col;
  } req_t;

endpackage

`default_nettype wire

>>> src/nand_bad_block_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Bad-block tracker for a NAND array: one 2-bit state (unknown, good, bad) per
// physical block, held in a single-port-write, registered-read memory. Each
// request beat gives exactly one result beat. After reset the table is swept
// to unknown, one entry per cycle, with in_ready low; then one request is
// taken per cycle while the output is not stalled. The table is read at the
// accepting edge; the state update, write back and output register load happen
// at the edge where the request stage advances, and the result beat is valid
// from it. That write is forwarded to a same-block read at that edge. The user
// must keep PAGE_BYTES and PAGES_PER_BLOCK powers of two; no check is made.
module nand_bad_block_tracker #(
  parameter int unsigned BLOCK_COUNT     = nbbt_pkg::BLOCK_COUNT_DEF,
  parameter int unsigned PAGE_BYTES      = nbbt_pkg::PAGE_BYTES_DEF,
  parameter int unsigned PAGES_PER_BLOCK = nbbt_pkg::PAGES_PER_BLOCK_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [26:0] in_byte_addr,
  input  wire logic [27:0] in_byte_len,
  input  wire logic [9:0]  in_block_num,
  input  wire logic [7:0]  in_factory_mark,
  input  wire logic        in_op_failed,
  input  wire logic [1:0]  in_ecc_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [9:0]       out_block_out,
  output logic [15:0]      out_page_out,
  output logic [10:0]      out_column_out,
  output logic             out_is_bad
);

  localparam int unsigned IDX_W = $clog2(BLOCK_COUNT);

  nbbt_pkg::req_t       s0_req;
  nbbt_pkg::req_t       s1_req_r;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_adv;
  logic                 in_acc;
  logic                 mem_ready;
  nbbt_pkg::blk_state_t cur_state;
  nbbt_pkg::blk_state_t new_state;
  nbbt_pkg::status_t    res_status;
  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           out_status_r;
  logic [9:0]           out_block_r;
  logic [15:0]          out_page_r;
  logic [10:0]          out_col_r;
  logic                 out_bad_r;

  nbbt_req_decode #(
    .BLOCK_COUNT    (BLOCK_COUNT),
    .PAGE_BYTES     (PAGE_BYTES),
    .PAGES_PER_BLOCK(PAGES_PER_BLOCK)
  ) u_decode (
    .op          (in_op),
    .byte_addr   (in_byte_addr),
    .byte_len    (in_byte_len),
    .block_num   (in_block_num),
    .factory_mark(in_factory_mark),
    .op_failed   (in_op_failed),
    .ecc_bits    (in_ecc_bits),
    .req         (s0_req)
  );

  // handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = mem_ready && (!s1_valid_r || s1_adv);
  assign in_acc   = in_valid && in_ready;

  nbbt_state_mem #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_idx  (s0_req.idx[IDX_W-1:0]),
    .rd_state(cur_state),
    .wr_en   (s1_adv && s1_req_r.wr),
    .wr_idx  (s1_req_r.idx[IDX_W-1:0]),
    .wr_state(new_state),
    .ready   (mem_ready)
  );

  // request stage
  assign s1_valid_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_req_r <= s0_req;
  end

  // state update
  always_comb begin
    new_state = cur_state;
    unique case (s1_req_r.kind)
      nbbt_pkg::OP_SCAN: begin
        if (cur_state == nbbt_pkg::BS_UNKNOWN) begin
          new_state = s1_req_r.marker_bad ? nbbt_pkg::BS_BAD : nbbt_pkg::BS_GOOD;
        end
      end
      nbbt_pkg::OP_FAIL: if (s1_req_r.failed) new_state = nbbt_pkg::BS_BAD;
      nbbt_pkg::OP_ACCESS, nbbt_pkg::OP_ECC: new_state = cur_state;
      default: new_state = cur_state;
    endcase
  end

  // result code
  always_comb begin
    if (s1_req_r.fixed) begin
      res_status = s1_req_r.status;
    end else begin
      unique case (new_state)
        nbbt_pkg::BS_BAD:  res_status = nbbt_pkg::RS_BAD;
        nbbt_pkg::BS_GOOD: res_status = nbbt_pkg::RS_GOOD;
        default:           res_status = nbbt_pkg::RS_SCAN;
      endcase
    end
  end

  // output register
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= res_status;
      out_block_r  <= s1_req_r.blk;
      out_page_r   <= s1_req_r.page;
      out_col_r    <= s1_req_r.col;
      out_bad_r    <= !s1_req_r.fixed && new_state == nbbt_pkg::BS_BAD;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_block_out  = out_block_r;
  assign out_page_out   = out_page_r;
  assign out_column_out = out_col_r;
  assign out_is_bad     = out_bad_r;

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted beat not held in request stage");

  a_bad_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_bad |-> out_status == nbbt_pkg::RS_BAD)
    else $error("bad flag without bad status");

  a_write_only_reports: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_req_r.wr |->
      s1_req_r.kind == nbbt_pkg::OP_SCAN || s1_req_r.kind == nbbt_pkg::OP_FAIL)
    else $error("table written by a non-report request");

endmodule

`default_nettype wire

>>> src/nbbt_req_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module nbbt_req_decode #(
  parameter int unsigned BLOCK_COUNT     = nbbt_pkg::BLOCK_COUNT_DEF,
  parameter int unsigned PAGE_BYTES      = nbbt_pkg::PAGE_BYTES_DEF,
  parameter int unsigned PAGES_PER_BLOCK = nbbt_pkg::PAGES_PER_BLOCK_DEF
) (
  input  wire logic [1:0]     op,
  input  wire logic [26:0]    byte_addr,
  input  wire logic [27:0]    byte_len,
  input  wire logic [9:0]     block_num,
  input  wire logic [7:0]     factory_mark,
  input  wire logic           op_failed,
  input  wire logic [1:0]     ecc_bits,
  output nbbt_pkg::req_t      req
);

  localparam int unsigned PB_SH  = $clog2(PAGE_BYTES);
  localparam int unsigned PPB_SH = $clog2(PAGES_PER_BLOCK);
  localparam logic [40:0] TOTAL_BYTES =
    41'(BLOCK_COUNT) * 41'(PAGES_PER_BLOCK) * 41'(PAGE_BYTES);

  logic [40:0] addr_x;
  logic [40:0] addr_end;
  logic        range_bad;
  logic [40:0] page_full;
  logic [40:0] blk_full;
  logic [40:0] col_full;
  logic [40:0] rpt_page_full;
  logic        rpt_blk_ok;

  // access range and address split
  assign addr_x    = 41'(byte_addr);
  assign addr_end  = addr_x + 41'(byte_len);
  assign range_bad = addr_end > TOTAL_BYTES;
  assign page_full = addr_x >> PB_SH;
  assign blk_full  = page_full >> PPB_SH;
  assign col_full  = addr_x & 41'(PAGE_BYTES - 1);

  // report block check and first page
  assign rpt_blk_ok    = 17'(block_num) < 17'(BLOCK_COUNT);
  assign rpt_page_full = 41'(block_num) << PPB_SH;

  always_comb begin
    req            = '0;
    req.kind       = nbbt_pkg::op_t'(op);
    req.marker_bad = factory_mark != nbbt_pkg::MARKER_GOOD;
    req.failed     = op_failed;
    req.status     = nbbt_pkg::RS_GOOD;
    unique case (nbbt_pkg::op_t'(op))
      nbbt_pkg::OP_ACCESS: begin
        if (byte_len == '0) begin
          req.fixed  = 1'b1;
          req.status = nbbt_pkg::RS_EMPTY;
        end else if (range_bad) begin
          req.fixed  = 1'b1;
          req.status = nbbt_pkg::RS_RANGE;
        end else begin
          req.idx  = blk_full[nbbt_pkg::IDX_MAX_W-1:0];
          req.blk  = blk_full[9:0];
          req.page = page_full[15:0];
          req.col  = col_full[10:0];
        end
      end
      nbbt_pkg::OP_SCAN, nbbt_pkg::OP_FAIL: begin
        req.blk = block_num;
        req.idx = nbbt_pkg::IDX_MAX_W'(block_num);
        if (rpt_blk_ok) begin
          req.wr   = 1'b1;
          req.page = rpt_page_full[15:0];
        end else begin
          req.fixed  = 1'b1;
          req.status = nbbt_pkg::RS_RANGE;
        end
      end
      nbbt_pkg::OP_ECC: begin
        req.fixed = 1'b1;
        unique case (ecc_bits)
          2'd0:    req.status = nbbt_pkg::RS_ECC_CLEAN;
          2'd1:    req.status = nbbt_pkg::RS_ECC_FIXED;
          default: req.status = nbbt_pkg::RS_ECC_FATAL;
        endcase
      end
      default: req.fixed = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

>>> src/nbbt_state_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module nbbt_state_mem #(
  parameter int unsigned BLOCK_COUNT = nbbt_pkg::BLOCK_COUNT_DEF,
  localparam int unsigned IDX_W      = $clog2(BLOCK_COUNT)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 rd_en,
  input  wire logic [IDX_W-1:0]     rd_idx,
  output nbbt_pkg::blk_state_t      rd_state,
  input  wire logic                 wr_en,
  input  wire logic [IDX_W-1:0]     wr_idx,
  input  wire nbbt_pkg::blk_state_t wr_state,
  output logic                      ready
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_COUNT - 1);

  nbbt_pkg::blk_state_t mem [BLOCK_COUNT];

  nbbt_pkg::mem_fsm_t   fsm_r, fsm_nxt;
  logic [IDX_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic                 clr_we;

  nbbt_pkg::blk_state_t rd_data_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 fwd_valid_r;
  logic [IDX_W-1:0]     fwd_idx_r;
  nbbt_pkg::blk_state_t fwd_state_r;

  logic                 we;
  logic [IDX_W-1:0]     we_idx;
  nbbt_pkg::blk_state_t we_state;

  // clear sweep next state
  always_comb begin
    fsm_nxt = fsm_r;
    unique case (fsm_r)
      nbbt_pkg::MF_CLEAR: if (clr_cnt_r == LAST_IDX) fsm_nxt = nbbt_pkg::MF_RUN;
      nbbt_pkg::MF_RUN:   fsm_nxt = nbbt_pkg::MF_RUN;
      default:            fsm_nxt = nbbt_pkg::MF_CLEAR;
    endcase
  end

  // clear sweep outputs
  always_comb begin
    clr_we = 1'b0;
    ready  = 1'b0;
    unique case (fsm_r)
      nbbt_pkg::MF_CLEAR: clr_we = 1'b1;
      nbbt_pkg::MF_RUN:   ready  = 1'b1;
      default:            clr_we = 1'b0;
    endcase
  end

  assign clr_cnt_nxt = clr_we ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r     <= nbbt_pkg::MF_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      fsm_r     <= fsm_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // write port shared by the sweep and the update stage
  assign we       = clr_we || wr_en;
  assign we_idx   = clr_we ? clr_cnt_r : wr_idx;
  assign we_state = clr_we ? nbbt_pkg::BS_UNKNOWN : wr_state;

  always_ff @(posedge clk) begin
    if (we) mem[we_idx] <= we_state;
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
      rd_idx_r  <= rd_idx;
    end
  end

  // last write, forwarded over a read of the same entry at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (we) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fwd_idx_r   <= we_idx;
      fwd_state_r <= we_state;
    end
  end

  assign rd_state = (fwd_valid_r && fwd_idx_r == rd_idx_r) ? fwd_state_r : rd_data_r;

  a_no_access_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !ready |-> !rd_en && !wr_en)
    else $error("table accessed during clear sweep");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready) |-> $past(clr_cnt_r) == LAST_IDX)
    else $error("clear sweep ended early");

endmodule

`default_nettype wire

>>> tb/tb_nand_bad_block_tracker.sv
`timescale 1ns / 1ps

module tb_nand_bad_block_tracker;

  localparam int unsigned BLOCKS      = nbbt_pkg::BLOCK_COUNT_DEF;
  localparam int unsigned PAGE_SIZE   = nbbt_pkg::PAGE_BYTES_DEF;
  localparam int unsigned BLOCK_PAGES = nbbt_pkg::PAGES_PER_BLOCK_DEF;
  localparam longint unsigned ARRAY_BYTES =
    longint'(BLOCKS) * longint'(BLOCK_PAGES) * longint'(PAGE_SIZE);

  localparam int RANDOM_ITEMS = 1100;
  localparam int POOL_SIZE    = 16;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTS   = 60;

  // device ecc status codes
  localparam logic [1:0] ECC_CLEAN = 2'd0;
  localparam logic [1:0] ECC_FIXED = 2'd1;
  localparam logic [1:0] ECC_FATAL = 2'd2;
  localparam logic [1:0] ECC_FATAL_ALT = 2'd3;

  // receiver stall modes
  localparam int RX_STREAM = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_SPARSE = 2;

  typedef struct packed {
    nbbt_pkg::op_t op;
    logic [26:0]   addr;
    logic [27:0]   len;
    logic [9:0]    blk;
    logic [7:0]    marker;
    logic          failed;
    logic [1:0]    ecc;
  } nand_req_t;

  typedef struct packed {
    nbbt_pkg::status_t status;
    logic [9:0]        blk;
    logic [15:0]       page;
    logic [10:0]       col;
    logic              bad;
  } blk_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [1:0]  in_op = '0;
  logic [26:0] in_byte_addr = '0;
  logic [27:0] in_byte_len = '0;
  logic [9:0]  in_block_num = '0;
  logic [7:0]  in_factory_mark = '0;
  logic        in_op_failed = 1'b0;
  logic [1:0]  in_ecc_bits = '0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire [2:0]   out_status;
  wire [9:0]   out_block_out;
  wire [15:0]  out_page_out;
  wire [10:0]  out_column_out;
  wire         out_is_bad;

  nand_bad_block_tracker DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_byte_addr    (in_byte_addr),
    .in_byte_len     (in_byte_len),
    .in_block_num    (in_block_num),
    .in_factory_mark (in_factory_mark),
    .in_op_failed    (in_op_failed),
    .in_ecc_bits     (in_ecc_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_block_out   (out_block_out),
    .out_page_out    (out_page_out),
    .out_column_out  (out_column_out),
    .out_is_bad      (out_is_bad)
  );

  nand_req_t            pending_reqs [$];
  blk_report_t          expected_reports [$];
  nbbt_pkg::blk_state_t shadow_state [BLOCKS];
  logic [9:0]           hot_blocks [POOL_SIZE];

  nand_req_t   cur_req;
  int unsigned total_reqs = 0;
  int unsigned req_count = 0;
  int unsigned checked_count = 0;
  int unsigned error_count = 0;
  int unsigned op_count [4];
  int unsigned status_count [8];

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // block state to reported status
  function automatic nbbt_pkg::status_t state_status(input nbbt_pkg::blk_state_t s);
    case (s)
      nbbt_pkg::BS_BAD:  return nbbt_pkg::RS_BAD;
      nbbt_pkg::BS_GOOD: return nbbt_pkg::RS_GOOD;
      default:           return nbbt_pkg::RS_SCAN;
    endcase
  endfunction

  // expected result of one request, updating the shadow table
  function automatic blk_report_t track_request(input nand_req_t r);
    blk_report_t     res;
    longint unsigned a;
    longint unsigned l;
    longint unsigned pg;
    longint unsigned b;
    res.status = nbbt_pkg::RS_GOOD;
    res.blk    = '0;
    res.page   = '0;
    res.col    = '0;
    res.bad    = 1'b0;
    a = r.addr;
    l = r.len;
    case (r.op)
      nbbt_pkg::OP_ACCESS: begin
        if (l == 0) begin
          res.status = nbbt_pkg::RS_EMPTY;
        end else if (a >= ARRAY_BYTES || l > ARRAY_BYTES - a) begin
          res.status = nbbt_pkg::RS_RANGE;
        end else begin
          pg = a / PAGE_SIZE;
          b  = pg / BLOCK_PAGES;
          if (b >= BLOCKS) begin
            res.status = nbbt_pkg::RS_RANGE;
          end else begin
            res.status = state_status(shadow_state[b]);
            res.blk    = b[9:0];
            res.page   = pg[15:0];
            res.col    = 11'(a % PAGE_SIZE);
            res.bad    = (shadow_state[b] == nbbt_pkg::BS_BAD);
          end
        end
      end
      nbbt_pkg::OP_ECC: begin
        res.status = (r.ecc == ECC_CLEAN) ? nbbt_pkg::RS_ECC_CLEAN :
                     (r.ecc == ECC_FIXED) ? nbbt_pkg::RS_ECC_FIXED :
                     nbbt_pkg::RS_ECC_FATAL;
      end
      default: begin
        if (r.blk >= BLOCKS) begin
          res.status = nbbt_pkg::RS_RANGE;
          res.blk    = r.blk;
        end else begin
          // a scan only sets an unknown block, a failure report marks bad only when failed is set
          if (r.op == nbbt_pkg::OP_SCAN) begin
            if (shadow_state[r.blk] == nbbt_pkg::BS_UNKNOWN)
              shadow_state[r.blk] = (r.marker != nbbt_pkg::MARKER_GOOD) ?
                                    nbbt_pkg::BS_BAD : nbbt_pkg::BS_GOOD;
          end else if (r.failed) begin
            shadow_state[r.blk] = nbbt_pkg::BS_BAD;
          end
          res.status = state_status(shadow_state[r.blk]);
          res.blk    = r.blk;
          res.page   = 16'(r.blk * BLOCK_PAGES);
          res.col    = '0;
          res.bad    = (shadow_state[r.blk] == nbbt_pkg::BS_BAD);
        end
      end
    endcase
    return res;
  endfunction

  // request with every field random, unused fields included
  function automatic nand_req_t random_req();
    nand_req_t r;
    r.op     = nbbt_pkg::op_t'(2'($urandom));
    r.addr   = 27'($urandom);
    r.len    = 28'($urandom_range(0, 32'(ARRAY_BYTES)));
    r.blk    = 10'($urandom);
    r.marker = 8'($urandom);
    r.failed = 1'($urandom);
    r.ecc    = 2'($urandom);
    return r;
  endfunction

  function automatic void push_access(input int unsigned addr, input int unsigned len);
    nand_req_t r;
    r      = random_req();
    r.op   = nbbt_pkg::OP_ACCESS;
    r.addr = 27'(addr);
    r.len  = 28'(len);
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_report(input nbbt_pkg::op_t op, input int unsigned blk,
                                      input logic [7:0] marker, input logic failed);
    nand_req_t r;
    r        = random_req();
    r.op     = op;
    r.blk    = 10'(blk);
    r.marker = marker;
    r.failed = failed;
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_ecc(input logic [1:0] ecc);
    nand_req_t r;
    r     = random_req();
    r.op  = nbbt_pkg::OP_ECC;
    r.ecc = ecc;
    pending_reqs.push_back(r);
  endfunction

  // random request, mostly aimed at a small pool of blocks so states get reused
  function automatic void push_random();
    nand_req_t       r;
    int unsigned     pick;
    longint unsigned room;
    r = random_req();
    if ($urandom_range(0, 3) != 0) r.blk = hot_blocks[$urandom_range(0, POOL_SIZE - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.op = nbbt_pkg::OP_ACCESS;
      if ($urandom_range(0, 3) != 0) r.addr = {r.blk, 17'($urandom)};
      room = ARRAY_BYTES - r.addr;
      pick = $urandom_range(0, 19);
      if (pick == 0)      r.len = '0;
      else if (pick == 1) r.len = 28'(room);
      else if (pick == 2) r.len = 28'(room + 1);
      else if (pick < 15) r.len = 28'($urandom_range(1, 4096));
      else                r.len = 28'($urandom_range(1, 32'(room)));
    end else if (pick < 65) begin
      r.op = nbbt_pkg::OP_SCAN;
      if ($urandom_range(0, 1) == 0) r.marker = nbbt_pkg::MARKER_GOOD;
    end else if (pick < 80) begin
      r.op = nbbt_pkg::OP_FAIL;
    end else begin
      r.op = nbbt_pkg::OP_ECC;
    end
    pending_reqs.push_back(r);
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got)
      report_error($sformatf("result %0d: %s expected 0x%0h, got 0x%0h",
                             checked_count, name, want, got));
  endtask

  // request driver: bursts of random length with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_reports.push_back(track_request(cur_req));
        op_count[int'(cur_req.op)]++;
        req_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_op           <= cur_req.op;
          in_byte_addr    <= cur_req.addr;
          in_byte_len     <= cur_req.len;
          in_block_num    <= cur_req.blk;
          in_factory_mark <= cur_req.marker;
          in_op_failed    <= cur_req.failed;
          in_ecc_bits     <= cur_req.ecc;
          in_valid        <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: stall modes of random length, plus one long hold-off
  int unsigned rx_mode = RX_STREAM;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_beats = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_beats++;
      if (!hold_done && rx_beats >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(RX_STREAM, RX_SPARSE);
        mode_left = $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STREAM: out_ready <= 1'b1;
          RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result monitor: compare each beat with the oldest expectation
  blk_report_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        report_error($sformatf("result with no request pending: status %0d block %0d",
                               out_status, out_block_out));
      end else begin
        want = expected_reports.pop_front();
        check_field("status", want.status, out_status);
        check_field("block_out", want.blk, out_block_out);
        check_field("page_out", want.page, out_page_out);
        check_field("column_out", want.col, out_column_out);
        check_field("is_bad", want.bad, out_is_bad);
      end
      status_count[out_status]++;
      checked_count++;
    end
  end

  // stimulus and end of run
  initial begin
    foreach (shadow_state[i]) shadow_state[i] = nbbt_pkg::BS_UNKNOWN;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (status_count[i]) status_count[i] = 0;
    hot_blocks[0] = 10'd0;
    hot_blocks[1] = 10'(BLOCKS - 1);
    for (int i = 2; i < POOL_SIZE; i++) hot_blocks[i] = 10'($urandom);

    // zero length, anywhere
    push_access(0, 0);
    push_access(32'(ARRAY_BYTES - 1), 0);
    // whole array, then one byte too long
    push_access(0, 32'(ARRAY_BYTES));
    push_access(1, 32'(ARRAY_BYTES));
    // last byte of the array, then running past the end
    push_access(32'(ARRAY_BYTES - 1), 1);
    push_access(32'(ARRAY_BYTES - 1), 2);
    // scan a fresh block good, then a scan of a known block keeps its state
    push_report(nbbt_pkg::OP_SCAN, 0, nbbt_pkg::MARKER_GOOD, 1'b0);
    push_access(5, 10);
    push_report(nbbt_pkg::OP_SCAN, 0, 8'h00, 1'b0);
    push_report(nbbt_pkg::OP_SCAN, BLOCKS - 1, 8'h00, 1'b0);
    push_access(32'(ARRAY_BYTES - 1), 1);
    push_report(nbbt_pkg::OP_SCAN, BLOCKS - 1, nbbt_pkg::MARKER_GOOD, 1'b0);
    // failure report without and with failure
    push_report(nbbt_pkg::OP_FAIL, 5, 8'h00, 1'b0);
    push_report(nbbt_pkg::OP_FAIL, 5, 8'h00, 1'b1);
    push_report(nbbt_pkg::OP_FAIL, 0, nbbt_pkg::MARKER_GOOD, 1'b1);
    push_report(nbbt_pkg::OP_SCAN, 7, 8'hFE, 1'b0);
    // access spanning blocks reports the first block, before and after a scan of it
    push_access(7 * (BLOCK_PAGES * PAGE_SIZE) - 100, 5000);
    push_report(nbbt_pkg::OP_SCAN, 6, nbbt_pkg::MARKER_GOOD, 1'b0);
    push_access(7 * (BLOCK_PAGES * PAGE_SIZE) - 100, 5000);
    // every ecc status
    push_ecc(ECC_CLEAN);
    push_ecc(ECC_FIXED);
    push_ecc(ECC_FATAL);
    push_ecc(ECC_FATAL_ALT);

    repeat (RANDOM_ITEMS) push_random();
    total_reqs = pending_reqs.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (req_count < total_reqs) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d access checks, %0d scans, %0d failure reports, %0d ecc",
             req_count, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("checked %0d results (good %0d, bad %0d, scan %0d, range %0d, empty %0d), %0d errors",
             checked_count, status_count[nbbt_pkg::RS_GOOD], status_count[nbbt_pkg::RS_BAD],
             status_count[nbbt_pkg::RS_SCAN], status_count[nbbt_pkg::RS_RANGE],
             status_count[nbbt_pkg::RS_EMPTY], error_count);
    if (error_count == 0) begin
      $display("tb_nand_bad_block_tracker passed");
    end else begin
      $display("tb_nand_bad_block_tracker failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("timeout: %0d of %0d requests accepted, %0d results pending",
             req_count, total_reqs, expected_reports.size());
    $display("tb_nand_bad_block_tracker failed");
    $finish;
  end

endmodule
